/* design/assert_macros.svh */
// Assertion macros shared by the wavetable mixer modules.
// Each macro wraps one clocked concurrent assertion with an asynchronous-reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* design/wvm_pkg.sv */
// Package of the wavetable voice mixer: constants, codes and shared types.
// Used by every module of the block; the channel interfaces do not use it.
`timescale 1ns / 1ps

package wvm_pkg;

	localparam int VOICES_DEF     = 4;
	localparam int WAVE_BYTES_DEF = 8192;
	localparam int RAW_W          = 13;
	localparam int PHASE_W        = 20;
	localparam int RECIP_SH       = 26;
	localparam int QDEPTH         = 2;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_VOICE = 2'd1;
	localparam logic [1:0] KIND_WAVE  = 2'd2;

	localparam logic [15:0] WAVE_CENTER = 16'd8;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_VOICE,
		OP_WAVE
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_SCALE,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  voice;
		logic [15:0] frequency;
		logic [7:0]  voice_volume;
		logic [7:0]  waveform;
		logic [12:0] wave_address;
		logic [7:0]  wave_byte;
		logic        last_in_buffer;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

/* design/wvm_in_if.sv */
// Input item channel of the wavetable voice mixer: valid, ready and item fields.
// Depends on nothing; the field widths are fixed.
`timescale 1ns / 1ps

interface wvm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  voice;
	logic [15:0] frequency;
	logic [7:0]  voice_volume;
	logic [7:0]  waveform;
	logic [12:0] wave_address;
	logic [7:0]  wave_byte;
	logic        last_in_buffer;

	modport source (
		output valid, kind, voice, frequency, voice_volume, waveform,
		output wave_address, wave_byte, last_in_buffer,
		input  ready
	);
	modport sink (
		input  valid, kind, voice, frequency, voice_volume, waveform,
		input  wave_address, wave_byte, last_in_buffer,
		output ready
	);
endinterface

/* design/wvm_out_if.sv */
// Result item channel of the wavetable voice mixer: valid, ready and sample fields.
// Depends on nothing; the field widths are fixed.
`timescale 1ns / 1ps

interface wvm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               sample_last;

	modport source (output valid, sample, sample_last, input ready);
	modport sink   (input valid, sample, sample_last, output ready);
endinterface

/* design/wvm_front.sv */
// Front part of the mixer: accepts input items, classifies them and queues them.
// Depends on wvm_pkg, wvm_in_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wvm_front (
	input  logic           clk,
	input  logic           arst_n,
	wvm_in_if.sink         items,
	output wvm_pkg::q_head_t head,
	input  logic           pop
);

	localparam int PTR_W = (wvm_pkg::QDEPTH > 1) ? $clog2(wvm_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(wvm_pkg::QDEPTH + 1);

	wvm_pkg::cmd_t fifo_q [wvm_pkg::QDEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             keep;
	logic             push;
	wvm_pkg::cmd_t    cmd_in;

	always_comb begin
		keep      = 1'b1;
		cmd_in.op = wvm_pkg::OP_TICK;
		case (items.kind)
			wvm_pkg::KIND_TICK:  cmd_in.op = wvm_pkg::OP_TICK;
			wvm_pkg::KIND_VOICE: cmd_in.op = wvm_pkg::OP_VOICE;
			wvm_pkg::KIND_WAVE:  cmd_in.op = wvm_pkg::OP_WAVE;
			default:             keep = 1'b0;
		endcase
		cmd_in.voice          = items.voice;
		cmd_in.frequency      = items.frequency;
		cmd_in.voice_volume   = items.voice_volume;
		cmd_in.waveform       = items.waveform;
		cmd_in.wave_address   = items.wave_address;
		cmd_in.wave_byte      = items.wave_byte;
		cmd_in.last_in_buffer = items.last_in_buffer;
	end

	assign items.ready = (cnt_q != CNT_W'(wvm_pkg::QDEPTH));
	assign push        = items.valid && items.ready && keep;
	assign head.valid  = (cnt_q != '0);
	assign head.cmd    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(wvm_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(wvm_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && (cnt_q == '0))
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && (cnt_q == CNT_W'(wvm_pkg::QDEPTH)))
	`ASSERT_CLK(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(wvm_pkg::QDEPTH))

endmodule

/* design/wvm_back.sv */
// Back part of the mixer: voice state, per-voice pipeline, wave memory, scaling, output.
// Depends on wvm_pkg, wvm_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wvm_back #(
	parameter int VOICES     = wvm_pkg::VOICES_DEF,
	parameter int WAVE_BYTES = wvm_pkg::WAVE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wvm_pkg::q_head_t head,
	output logic             pop,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	wvm_out_if.source        samples
);

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW    = $clog2(WAVE_BYTES);
	localparam int RECIP = (1 << wvm_pkg::RECIP_SH) / WAVE_BYTES;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = wvm_pkg::RAW_W + RW;
	localparam int QW    = PW - wvm_pkg::RECIP_SH;
	localparam int MW    = wvm_pkg::RAW_W + 1;

	wvm_pkg::bk_state_t state_q, state_d;

	logic [wvm_pkg::PHASE_W-1:0] phase_q [VOICES];
	logic [15:0]                 freq_q  [VOICES];
	logic [7:0]                  gain_q  [VOICES];
	logic [7:0]                  wave_q  [VOICES];
	logic [VW-1:0]               vc_q;
	logic [7:0]                  master_q;
	logic                        last_q;
	logic [15:0]                 acc_q;
	logic signed [24:0]          prod_q;
	logic                        out_valid_q;
	logic [15:0]                 sample_q;
	logic                        sample_last_q;

	logic [7:0] mem_q [WAVE_BYTES];

	logic                       v_s1, wr_s1, act_s1;
	logic [wvm_pkg::RAW_W-1:0]  raw_s1;
	logic [7:0]                 gain_s1, wbyte_s1;
	logic                       v_s2, wr_s2, act_s2;
	logic [wvm_pkg::RAW_W-1:0]  raw_s2;
	logic [PW-1:0]              prod_s2;
	logic [7:0]                 gain_s2, wbyte_s2;
	logic                       v_s3, wr_s3, act_s3;
	logic [AW-1:0]              addr_s3;
	logic [7:0]                 gain_s3, wbyte_s3;
	logic                       v_s4, act_s4;
	logic [7:0]                 rdata_s4, gain_s4;
	logic                       v_s5, act_s5;
	logic [15:0]                term_s5;

	logic                        issue, inject, voice_wr, tick_start, load_out, vc_last, busy;
	logic                        act_c;
	logic [wvm_pkg::PHASE_W-1:0] phase_c;
	logic [wvm_pkg::RAW_W-1:0]   raw_c;
	logic [QW-1:0]               quot_c;
	logic [MW-1:0]               rem_c;
	logic [MW-1:0]               fix_c;
	logic [15:0]                 term_c;
	logic signed [24:0]          mul_c;
	logic signed [24:0]          scaled_c;
	logic [15:0]                 sat_c;

	assign vc_last = (vc_q == VW'(VOICES - 1));
	assign busy    = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wvm_pkg::BK_IDLE:  if (head.valid && head.cmd.op == wvm_pkg::OP_TICK) begin
				state_d = wvm_pkg::BK_ISSUE;
			end
			wvm_pkg::BK_ISSUE: if (vc_last) begin
				state_d = wvm_pkg::BK_DRAIN;
			end
			wvm_pkg::BK_DRAIN: if (!busy) begin
				state_d = wvm_pkg::BK_SCALE;
			end
			wvm_pkg::BK_SCALE: state_d = wvm_pkg::BK_EMIT;
			wvm_pkg::BK_EMIT:  if (!out_valid_q || samples.ready) begin
				state_d = wvm_pkg::BK_IDLE;
			end
			default:           state_d = wvm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		issue      = 1'b0;
		inject     = 1'b0;
		voice_wr   = 1'b0;
		tick_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			wvm_pkg::BK_IDLE: begin
				pop        = head.valid;
				tick_start = head.valid && (head.cmd.op == wvm_pkg::OP_TICK);
				inject     = head.valid && (head.cmd.op == wvm_pkg::OP_WAVE);
				voice_wr   = head.valid && (head.cmd.op == wvm_pkg::OP_VOICE)
					&& (int'(head.cmd.voice) < VOICES);
			end
			wvm_pkg::BK_ISSUE: issue = 1'b1;
			wvm_pkg::BK_EMIT:  load_out = !out_valid_q || samples.ready;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// advance the selected voice's phase and form its raw wave address
	assign act_c   = (freq_q[vc_q] != '0) && (gain_q[vc_q] != '0);
	assign phase_c = phase_q[vc_q] + {4'b0, freq_q[vc_q]};
	assign raw_c   = {wave_q[vc_q], phase_c[wvm_pkg::PHASE_W-1 -: 5]};

	// reduce modulo the memory size from the registered reciprocal product
	assign quot_c = prod_s2[PW-1:wvm_pkg::RECIP_SH];
	assign rem_c  = {1'b0, raw_s2} - MW'(MW'(quot_c) * MW'(WAVE_BYTES));
	assign fix_c  = (rem_c >= MW'(WAVE_BYTES)) ? rem_c - MW'(WAVE_BYTES) : rem_c;

	assign term_c = 16'(({8'b0, rdata_s4} - wvm_pkg::WAVE_CENTER) * {8'b0, gain_s4});

	assign mul_c    = $signed({{9{acc_q[15]}}, acc_q}) * $signed({17'b0, master_q});
	assign scaled_c = prod_q[24] ? ((prod_q + 25'sd15) >>> 4) : (prod_q >>> 4);
	always_comb begin
		if (scaled_c > 25'sd32767) begin
			sat_c = 16'h7fff;
		end else if (scaled_c < -25'sd32768) begin
			sat_c = 16'h8000;
		end else begin
			sat_c = scaled_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wvm_pkg::BK_IDLE;
			vc_q        <= '0;
			master_q    <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				phase_q[i] <= '0;
				freq_q[i]  <= '0;
				gain_q[i]  <= '0;
				wave_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1    <= issue || inject;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			if (cfg_we) begin
				master_q <= cfg_wdata;
			end
			if (tick_start) begin
				vc_q <= '0;
			end else if (issue) begin
				vc_q <= vc_last ? '0 : vc_q + 1'b1;
			end
			if (issue && act_c) begin
				phase_q[vc_q] <= phase_c;
			end
			if (voice_wr) begin
				freq_q[VW'(head.cmd.voice)] <= head.cmd.frequency;
				gain_q[VW'(head.cmd.voice)] <= head.cmd.voice_volume;
				wave_q[VW'(head.cmd.voice)] <= head.cmd.waveform;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_s1    <= inject;
		act_s1   <= issue && act_c;
		raw_s1   <= inject ? head.cmd.wave_address : raw_c;
		gain_s1  <= gain_q[vc_q];
		wbyte_s1 <= head.cmd.wave_byte;

		wr_s2    <= wr_s1;
		act_s2   <= act_s1;
		raw_s2   <= raw_s1;
		prod_s2  <= PW'(raw_s1) * PW'(RECIP);
		gain_s2  <= gain_s1;
		wbyte_s2 <= wbyte_s1;

		wr_s3    <= wr_s2;
		act_s3   <= act_s2;
		addr_s3  <= AW'(fix_c);
		gain_s3  <= gain_s2;
		wbyte_s3 <= wbyte_s2;

		act_s4   <= act_s3 && !wr_s3;
		gain_s4  <= gain_s3;

		act_s5   <= act_s4;
		term_s5  <= term_c;

		if (tick_start) begin
			acc_q  <= '0;
			last_q <= head.cmd.last_in_buffer;
		end else if (v_s5 && act_s5) begin
			acc_q <= acc_q + term_s5;
		end
		prod_q <= mul_c;
		if (load_out) begin
			sample_q      <= sat_c;
			sample_last_q <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && wr_s3) begin
			mem_q[addr_s3] <= wbyte_s3;
		end
		rdata_s4 <= mem_q[addr_s3];
	end

	assign samples.valid       = out_valid_q;
	assign samples.sample      = sample_q;
	assign samples.sample_last = sample_last_q;

	`ASSERT_CLK(a_pop_idle, clk, arst_n, pop |-> state_q == wvm_pkg::BK_IDLE)
	`ASSERT_CLK(a_scale_drained, clk, arst_n, (state_q == wvm_pkg::BK_SCALE) |-> !busy)
	`ASSERT_CLK(a_out_from_emit, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == wvm_pkg::BK_EMIT)
	`ASSERT_CLK(a_issue_range, clk, arst_n, (state_q == wvm_pkg::BK_ISSUE) |-> int'(vc_q) < VOICES)

endmodule

/* design/wavetable_voice_mixer_unit.sv */
// Top level of the wavetable voice mixer: front queue and back mixing engine.
// Depends on wvm_pkg, wvm_in_if, wvm_out_if, wvm_front and wvm_back.
//
// Usage: items arrive on the items channel (valid/ready). kind 0 is a tick that
// yields one sample item on the samples channel; kind 1 writes a voice's frequency,
// volume and waveform; kind 2 writes one wave memory byte; kind 3 is dropped.
// master_volume must be written by the user through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. The front holds up to two items
// in a queue, so the channel keeps accepting while a sample waits at the output register.
// Operation: a write item is taken in the idle state of the back engine. A tick
// passes from entering the engine to its sample at the output as follows: the
// voices are issued in turn through the shared wave memory read port and multiplier,
// five pipeline stages of address reduction, memory read and term product, then
// master scaling in the SCALE and EMIT states. Ticks are processed one at a time:
// a new item is taken only after the tick's sample is loaded at the output.
// Reset clears voice state, phases, master_volume, the queue and the output; wave
// memory holds no defined value until written. When the receiver stalls, the
// sample is held, the engine waits, and the queue fills before items stall.
`timescale 1ns / 1ps

module wavetable_voice_mixer_unit #(
	parameter int VOICES     = wvm_pkg::VOICES_DEF,
	parameter int WAVE_BYTES = wvm_pkg::WAVE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wvm_in_if.sink     items,
	wvm_out_if.source  samples,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	wvm_pkg::q_head_t head;
	logic             pop;

	wvm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.head   (head),
		.pop    (pop)
	);

	wvm_back #(
		.VOICES     (VOICES),
		.WAVE_BYTES (WAVE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples)
	);

endmodule
